// ----- hw/rtl/dft_pkg.sv -----
// Package for the dielectric Fresnel transmittance block.
// Fixed-point formats, pipeline depths, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dft_pkg;

    // fraction bits of the cosine and the result
    localparam int unsigned FRAC_BITS = 15;
    // internal fraction bits
    localparam int unsigned WQ        = 30;
    localparam int unsigned C_SHIFT   = WQ - FRAC_BITS;

    localparam logic [63:0] ONE30     = 64'd1 << WQ;
    localparam logic [46:0] CAP2      = 47'd1 << 46;
    localparam logic [30:0] TMAX      = (FRAC_BITS >= 16) ? 31'd65535 : (31'd1 << FRAC_BITS);

    // square root: one result bit per stage
    localparam int unsigned SQ_STEPS  = 47;
    // ratio divider: one quotient bit per stage
    localparam int unsigned DV_STEPS  = 47;
    // dividend bits of the ratio that are not zero fill
    localparam int unsigned DV_NUM    = DV_STEPS - WQ;
    // bits of the eta ratio quotient
    localparam int unsigned R2_BITS   = 62;

    localparam logic [15:0] ETA_INNER_RST = 16'd6144;
    localparam logic [15:0] ETA_OUTER_RST = 16'd4096;

    typedef enum logic [0:0] {
        CFG_ETA_INNER = 1'b0,
        CFG_ETA_OUTER = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- hw/rtl/dielectric_fresnel_transmittance.sv -----
// Dielectric Fresnel transmittance, fully pipelined top level.
// Depends on dft_pkg.
//
// Usage:
//   Input channel i_valid / o_ready carries one signed Q1.15 cosine per item.
//   Output channel o_valid / i_ready returns 1 - F as unsigned Q1.15 plus a
//   total reflection flag, one result item per input item, in order.
//   Configuration: i_cfg_we writes eta_inner (index 0) or eta_outer (index 1),
//   both unsigned Q4.12, from i_cfg_data.
//   Throughput: one item per cycle while o_ready is high. Pipeline: 47-stage
//   square root, 47-stage two-lane ratio divider, plus multiply and normalize
//   stages.
//   The squared index ratio is formed by a bit-serial divider after reset and
//   after every configuration write: o_ready stays low while it runs.
//   Reset clears all valid bits and loads eta_inner = 1.5, eta_outer = 1.0.
//   When the receiver stalls, a skid register takes the one item in flight
//   at the pipeline exit and the whole pipeline holds; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module dielectric_fresnel_transmittance (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_cos_theta,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic             [15:0] o_transmittance,
    output logic                    o_total_reflection,
    input  wire logic               i_cfg_we,
    input  wire logic         [0:0] i_cfg_idx,
    input  wire logic        [15:0] i_cfg_data
);

    localparam int unsigned SQ = dft_pkg::SQ_STEPS;
    localparam int unsigned DV = dft_pkg::DV_STEPS;
    localparam int unsigned WQ = dft_pkg::WQ;
    localparam int unsigned DV_SHIFT = dft_pkg::DV_NUM;

    // ---------------- configuration and eta ratio ----------------
    logic [15:0] r_eta_in, r_eta_out;
    logic        r_dv_ld;
    logic  [5:0] r_dv_cnt;
    logic [61:0] r_dv_q;
    logic [32:0] r_dv_rem;
    logic [31:0] r_dv_den;
    logic [61:0] n_dv_q;
    logic [32:0] n_dv_rem;
    logic [32:0] w_dv_t;
    logic [15:0] w_eo;
    logic        w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_in  <= dft_pkg::ETA_INNER_RST;
            r_eta_out <= dft_pkg::ETA_OUTER_RST;
        end else if (i_cfg_we) begin
            case (dft_pkg::t_cfg_idx'(i_cfg_idx))
                dft_pkg::CFG_ETA_INNER: r_eta_in  <= i_cfg_data;
                dft_pkg::CFG_ETA_OUTER: r_eta_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eo   = (r_eta_out == 16'd0) ? 16'd1 : r_eta_out;
    assign w_dv_t = {r_dv_rem[31:0], r_dv_q[61]};

    always_comb begin
        n_dv_rem = w_dv_t;
        n_dv_q   = {r_dv_q[60:0], 1'b0};
        if (w_dv_t >= {1'b0, r_dv_den}) begin
            n_dv_rem  = w_dv_t - {1'b0, r_dv_den};
            n_dv_q[0] = 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle: r2 = ei^2 * 2^30 / eo^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ld  <= 1'b1;
            r_dv_cnt <= 6'd0;
        end else if (i_cfg_we) begin
            r_dv_ld  <= 1'b1;
        end else if (r_dv_ld) begin
            r_dv_ld  <= 1'b0;
            r_dv_cnt <= 6'(dft_pkg::R2_BITS);
            r_dv_q   <= {32'(r_eta_in) * 32'(r_eta_in), 30'd0};
            r_dv_rem <= 33'd0;
            r_dv_den <= 32'(w_eo) * 32'(w_eo);
        end else if (r_dv_cnt != 6'd0) begin
            r_dv_cnt <= r_dv_cnt - 6'd1;
            r_dv_q   <= n_dv_q;
            r_dv_rem <= n_dv_rem;
        end
    end

    assign w_busy = r_dv_ld | (r_dv_cnt != 6'd0);

    // ---------------- pipeline control ----------------
    logic r_k_v, r_o_v;
    logic w_en, w_acc;

    assign w_en    = ~r_k_v;
    assign o_ready = w_en & ~w_busy;
    assign w_acc   = i_valid & o_ready;

    // ---------------- stage 0: |cos|, saturate, to Q.30 ----------------
    logic        r_s0_v;
    logic [30:0] r_s0_c;
    logic [16:0] w_cmag;
    logic [31:0] w_cm32;
    logic [31:0] w_c32;

    always_comb begin
        w_cmag = i_cos_theta[15] ? (17'h10000 - {1'b0, i_cos_theta}) : {1'b0, i_cos_theta};
        w_cm32 = {15'd0, w_cmag};
        if (w_cm32 > (32'd1 << dft_pkg::FRAC_BITS))
            w_cm32 = 32'd1 << dft_pkg::FRAC_BITS;
        w_c32 = w_cm32 << dft_pkg::C_SHIFT;
    end

    // ---------------- stage 1: c*c ----------------
    logic        r_s1_v;
    logic [30:0] r_s1_c, r_s1_cc;
    logic [61:0] w_ccp;
    assign w_ccp = r_s0_c * r_s0_c;

    // ---------------- sqrt entry and stages ----------------
    logic        r_sq_v    [0:SQ];
    logic [63:0] r_sq_x    [0:SQ];
    logic [46:0] r_sq_root [0:SQ];
    logic [48:0] r_sq_rem  [0:SQ];
    logic [30:0] r_sq_c    [0:SQ];
    logic [30:0] r_sq_cc   [0:SQ];
    logic        r_sq_tir  [0:SQ];
    logic [46:0] n_sq_root [1:SQ];
    logic [48:0] n_sq_rem  [1:SQ];
    logic [50:0] w_sq_t    [1:SQ];
    logic [50:0] w_sq_trial[1:SQ];
    logic  [1:0] w_sq_pair [1:SQ];
    logic [63:0] w_g2;

    assign w_g2 = {2'd0, r_dv_q} + {33'd0, r_s1_cc} - dft_pkg::ONE30;

    always_comb begin
        for (int i = 1; i <= SQ; i++) begin
            w_sq_pair[i] = 2'b00;
            if (2 * (SQ - i) >= WQ)
                w_sq_pair[i] = r_sq_x[i-1][((2 * (SQ - i) >= WQ) ? (2 * (SQ - i) - WQ) : 0) +: 2];
            w_sq_t[i]     = {r_sq_rem[i-1], w_sq_pair[i]};
            w_sq_trial[i] = {2'b00, r_sq_root[i-1], 2'b01};
            if (w_sq_t[i] >= w_sq_trial[i]) begin
                n_sq_rem[i]  = 49'(w_sq_t[i] - w_sq_trial[i]);
                n_sq_root[i] = {r_sq_root[i-1][45:0], 1'b1};
            end else begin
                n_sq_rem[i]  = 49'(w_sq_t[i]);
                n_sq_root[i] = {r_sq_root[i-1][45:0], 1'b0};
            end
        end
    end

    // ---------------- stage A: g+c, |g-c|, c*g partial products ----------------
    logic        r_a_v, r_a_tir;
    logic [47:0] r_a_a, r_a_b;
    logic [30:0] r_a_cc;
    logic [54:0] r_a_plo;
    logic [53:0] r_a_phi;
    logic [46:0] w_g;
    logic [30:0] w_gc;
    logic [47:0] w_b, w_a;

    assign w_g  = r_sq_root[SQ];
    assign w_gc = r_sq_c[SQ];
    assign w_b  = 48'(w_g) + 48'(w_gc);
    assign w_a  = (w_g >= 47'(w_gc)) ? 48'(w_g - 47'(w_gc)) : 48'(47'(w_gc) - w_g);

    // ---------------- stage B: cg, numerators and denominators ----------------
    logic        r_b_v, r_b_tir;
    logic [47:0] r_b_num [0:1];
    logic [47:0] r_b_den [0:1];
    logic [77:0] w_cgs;
    logic [47:0] w_cg;
    logic [48:0] w_nn;
    logic [47:0] w_nmag, w_d;

    always_comb begin
        w_cgs  = (78'(r_a_phi) << 24) + 78'(r_a_plo);
        w_cg   = w_cgs[77:30];
        w_nn   = 49'(w_cg) + 49'(r_a_cc) - 49'(dft_pkg::ONE30);
        w_nmag = w_nn[48] ? 48'(-w_nn) : 48'(w_nn);
        w_d    = w_cg + 48'(dft_pkg::ONE30) - 48'(r_a_cc);
    end

    // ---------------- stage Z: normalize shift amount ----------------
    logic        r_z_v, r_z_tir;
    logic [47:0] r_z_num [0:1];
    logic [47:0] r_z_den [0:1];
    logic  [4:0] r_z_sh  [0:1];
    logic [47:0] w_or    [0:1];
    logic  [5:0] w_len   [0:1];
    logic  [4:0] w_sh    [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_or[l]  = r_b_num[l] | r_b_den[l];
            w_len[l] = 6'd0;
            for (int j = 0; j < 48; j++)
                if (w_or[l][j]) w_len[l] = 6'(j + 1);
            w_sh[l] = (w_len[l] > 6'd32) ? 5'(w_len[l] - 6'd32) : 5'd0;
        end
    end

    // ---------------- divider entry and stages ----------------
    logic        r_dq_v   [0:DV];
    logic        r_dq_tir [0:DV];
    logic [31:0] r_dq_rem [0:DV][0:1];
    logic [31:0] r_dq_den [0:DV][0:1];
    logic [16:0] r_dq_num [0:DV][0:1];
    logic [46:0] r_dq_q   [0:DV][0:1];
    logic        r_dq_sat [0:DV][0:1];
    logic [31:0] n_dq_rem [1:DV][0:1];
    logic [46:0] n_dq_q   [1:DV][0:1];
    logic [32:0] w_dq_t   [1:DV][0:1];
    logic [31:0] w_ns     [0:1];
    logic [31:0] w_ds     [0:1];
    logic        w_sat0   [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ns[l]   = 32'(r_z_num[l] >> r_z_sh[l]);
            w_ds[l]   = 32'(r_z_den[l] >> r_z_sh[l]);
            w_sat0[l] = (w_ds[l] == 32'd0) || ({17'd0, w_ns[l]} >= {w_ds[l], 17'd0});
        end
    end

    always_comb begin
        for (int i = 1; i <= DV; i++) begin
            for (int l = 0; l < 2; l++) begin
                w_dq_t[i][l] = {r_dq_rem[i-1][l], 1'b0};
                if (DV - i >= WQ)
                    w_dq_t[i][l][0] =
                        r_dq_num[i-1][l][(DV - i >= WQ) ? (DV - i - WQ) : 0];
                if (w_dq_t[i][l] >= {1'b0, r_dq_den[i-1][l]}) begin
                    n_dq_rem[i][l] = 32'(w_dq_t[i][l] - {1'b0, r_dq_den[i-1][l]});
                    n_dq_q[i][l]   = {r_dq_q[i-1][l][45:0], 1'b1};
                end else begin
                    n_dq_rem[i][l] = 32'(w_dq_t[i][l]);
                    n_dq_q[i][l]   = {r_dq_q[i-1][l][45:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage E: saturate ratios ----------------
    logic        r_e_v, r_e_tir;
    logic [30:0] r_e_q1;
    logic [46:0] r_e_q2;
    logic [30:0] w_q1;
    logic [46:0] w_q2;

    always_comb begin
        if (r_dq_sat[DV][0] || (r_dq_q[DV][0] > 47'(dft_pkg::ONE30)))
            w_q1 = 31'(dft_pkg::ONE30);
        else
            w_q1 = 31'(r_dq_q[DV][0]);
        if (r_dq_sat[DV][1] || (r_dq_q[DV][1] > dft_pkg::CAP2))
            w_q2 = dft_pkg::CAP2;
        else
            w_q2 = r_dq_q[DV][1];
    end

    // ---------------- stage F: squares ----------------
    logic        r_f_v, r_f_tir;
    logic [30:0] r_f_s1;
    logic [45:0] r_f_hh;
    logic [46:0] r_f_hl;
    logic [47:0] r_f_ll;
    logic [61:0] w_s1p;
    assign w_s1p = r_e_q1 * r_e_q1;

    // ---------------- stage G: s2 sum, 1 + s2 ----------------
    logic        r_g_v, r_g_tir;
    logic [30:0] r_g_s1;
    logic [62:0] r_g_m;
    logic [92:0] w_s2s;
    assign w_s2s = (93'(r_f_hh) << 48) + (93'(r_f_hl) << 25) + 93'(r_f_ll);

    // ---------------- stage H: s1 * (1 + s2) partial products ----------------
    logic        r_h_v, r_h_tir;
    logic [51:0] r_h_p0, r_h_p1, r_h_p2;

    // ---------------- stage I: reflectance to transmittance ----------------
    logic        r_i_v, r_i_tir;
    logic [15:0] r_i_t;
    logic [93:0] w_prod;
    logic [62:0] w_f;
    logic [30:0] w_tt;
    logic [15:0] w_t;

    always_comb begin
        w_prod = (94'(r_h_p2) << 42) + (94'(r_h_p1) << 21) + 94'(r_h_p0);
        w_f    = w_prod[93:31];
        w_tt   = 31'd0;
        if (w_f < 63'(dft_pkg::ONE30))
            w_tt = 31'((63'(dft_pkg::ONE30) - w_f) >> dft_pkg::C_SHIFT);
        if (w_tt > dft_pkg::TMAX)
            w_tt = dft_pkg::TMAX;
        w_t = r_h_tir ? 16'd0 : 16'(w_tt);
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            for (int i = 0; i <= SQ; i++) r_sq_v[i] <= 1'b0;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_z_v  <= 1'b0;
            for (int i = 0; i <= DV; i++) r_dq_v[i] <= 1'b0;
            r_e_v  <= 1'b0;
            r_f_v  <= 1'b0;
            r_g_v  <= 1'b0;
            r_h_v  <= 1'b0;
            r_i_v  <= 1'b0;
        end else if (w_en) begin
            r_s0_v    <= w_acc;
            r_s1_v    <= r_s0_v;
            r_sq_v[0] <= r_s1_v;
            for (int i = 1; i <= SQ; i++) r_sq_v[i] <= r_sq_v[i-1];
            r_a_v     <= r_sq_v[SQ];
            r_b_v     <= r_a_v;
            r_z_v     <= r_b_v;
            r_dq_v[0] <= r_z_v;
            for (int i = 1; i <= DV; i++) r_dq_v[i] <= r_dq_v[i-1];
            r_e_v     <= r_dq_v[DV];
            r_f_v     <= r_e_v;
            r_g_v     <= r_f_v;
            r_h_v     <= r_g_v;
            r_i_v     <= r_h_v;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_c  <= w_c32[30:0];

            r_s1_c  <= r_s0_c;
            r_s1_cc <= 31'(w_ccp >> WQ);

            r_sq_x[0]    <= {1'b0, w_g2[62:0]};
            r_sq_root[0] <= 47'd0;
            r_sq_rem[0]  <= 49'd0;
            r_sq_c[0]    <= r_s1_c;
            r_sq_cc[0]   <= r_s1_cc;
            r_sq_tir[0]  <= w_g2[63];
            for (int i = 1; i <= SQ; i++) begin
                r_sq_x[i]    <= r_sq_x[i-1];
                r_sq_root[i] <= n_sq_root[i];
                r_sq_rem[i]  <= n_sq_rem[i];
                r_sq_c[i]    <= r_sq_c[i-1];
                r_sq_cc[i]   <= r_sq_cc[i-1];
                r_sq_tir[i]  <= r_sq_tir[i-1];
            end

            r_a_a   <= w_a;
            r_a_b   <= w_b;
            r_a_cc  <= r_sq_cc[SQ];
            r_a_plo <= w_gc * w_g[23:0];
            r_a_phi <= w_gc * w_g[46:24];
            r_a_tir <= r_sq_tir[SQ] | (w_b == 48'd0);

            r_b_num[0] <= r_a_a;
            r_b_den[0] <= r_a_b;
            r_b_num[1] <= w_nmag;
            r_b_den[1] <= w_d;
            r_b_tir    <= r_a_tir;

            for (int l = 0; l < 2; l++) begin
                r_z_num[l] <= r_b_num[l];
                r_z_den[l] <= r_b_den[l];
                r_z_sh[l]  <= w_sh[l];
            end
            r_z_tir <= r_b_tir;

            r_dq_tir[0] <= r_z_tir;
            for (int l = 0; l < 2; l++) begin
                r_dq_rem[0][l] <= 32'(w_ns[l] >> DV_SHIFT);
                r_dq_den[0][l] <= w_ds[l];
                r_dq_num[0][l] <= w_ns[l][16:0];
                r_dq_q[0][l]   <= 47'd0;
                r_dq_sat[0][l] <= w_sat0[l];
            end
            for (int i = 1; i <= DV; i++) begin
                r_dq_tir[i] <= r_dq_tir[i-1];
                for (int l = 0; l < 2; l++) begin
                    r_dq_rem[i][l] <= n_dq_rem[i][l];
                    r_dq_den[i][l] <= r_dq_den[i-1][l];
                    r_dq_num[i][l] <= r_dq_num[i-1][l];
                    r_dq_q[i][l]   <= n_dq_q[i][l];
                    r_dq_sat[i][l] <= r_dq_sat[i-1][l];
                end
            end

            r_e_q1  <= w_q1;
            r_e_q2  <= w_q2;
            r_e_tir <= r_dq_tir[DV];

            r_f_s1  <= 31'(w_s1p >> WQ);
            r_f_hh  <= r_e_q2[46:24] * r_e_q2[46:24];
            r_f_hl  <= r_e_q2[46:24] * r_e_q2[23:0];
            r_f_ll  <= r_e_q2[23:0] * r_e_q2[23:0];
            r_f_tir <= r_e_tir;

            // the square of the second ratio is kept modulo 2^64 before scaling
            r_g_s1  <= r_f_s1;
            r_g_m   <= 63'(w_s2s[63:30]) + 63'(dft_pkg::ONE30);
            r_g_tir <= r_f_tir;

            r_h_p0  <= r_g_s1 * r_g_m[20:0];
            r_h_p1  <= r_g_s1 * r_g_m[41:21];
            r_h_p2  <= r_g_s1 * r_g_m[62:42];
            r_h_tir <= r_g_tir;

            r_i_t   <= w_t;
            r_i_tir <= r_h_tir;
        end
    end

    // ---------------- output register and skid ----------------
    logic [15:0] r_o_t, r_k_t;
    logic        r_o_f, r_k_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_k_v <= 1'b0;
        end else if (!r_o_v || i_ready) begin
            if (r_k_v) begin
                r_o_v <= 1'b1;
                r_o_t <= r_k_t;
                r_o_f <= r_k_f;
                r_k_v <= 1'b0;
            end else begin
                r_o_v <= r_i_v;
                r_o_t <= r_i_t;
                r_o_f <= r_i_tir;
            end
        end else if (r_i_v && !r_k_v) begin
            // receiver stalled: park the item leaving the pipeline
            r_k_v <= 1'b1;
            r_k_t <= r_i_t;
            r_k_f <= r_i_tir;
        end
    end

    assign o_valid            = r_o_v;
    assign o_transmittance    = r_o_t;
    assign o_total_reflection = r_o_f;

endmodule

`default_nettype wire
